FILE: rtl/dsir_pkg.sv
// ----------------------------------------------------------------------------
// Display status / interrupt register package
// Shared item and result types, register offsets and line constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dsir_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_LINE   = 2'd2,
    KIND_HBLANK = 2'd3
  } kind_e;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic [15:0] REG_DISPSTAT = 16'h0004;
  localparam logic [15:0] REG_GATE     = 16'h0208;
  localparam logic [15:0] REG_IRQ_EN   = 16'h0210;
  localparam logic [15:0] REG_IRQ_FLAG = 16'h0214;

  localparam logic [8:0] VBLANK_LINE = 9'd192;
  localparam logic [8:0] LAST_LINE   = 9'd262;
  localparam logic [8:0] FB_FIRST    = 9'd2;
  localparam logic [8:0] FB_END      = 9'd194;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef struct packed {
    kind_e        kind;
    logic [15:0]  reg_offset;
    logic [1:0]   access_size;
    logic [31:0]  write_data;
    logic [8:0]   line_number;
  } item_t;

  typedef struct packed {
    logic [31:0]  read_data;
    logic         vblank_dma;
    logic         hblank_dma;
    logic         framebuffer_dma;
    logic [31:0]  pending_flags;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/display_status_interrupt_regs_core.sv
// ----------------------------------------------------------------------------
// Display status and interrupt register block
// Stream wrapper: input beat register, register file, result register.
// ----------------------------------------------------------------------------
// Each input beat is a bus read, a masked bus write, a line-start event or an
// hblank-start event, and yields exactly one result beat carrying the read
// value, the three DMA trigger pulses and the flag register after the beat.
// The block takes one beat per cycle while the result side keeps up: a beat is
// held in the input register, is decoded against the register file there and
// lands in the result register. Write is_main_cpu only when idle.
`default_nettype none

module display_status_interrupt_regs_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_wr_en_i,
  input  wire logic         cfg_wr_data_i,   // is_main_cpu
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [15:0] reg_offset, [17:16] access_size, [49:18] write_data,
  // [58:50] line_number, [63:59] zero
  input  wire logic [63:0]  s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,    // [1:0] kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] read_data, [32] vblank_dma, [33] hblank_dma, [34] framebuffer_dma,
  // [66:35] pending_flags, [71:67] zero
  output logic [71:0]       m_axis_tdata
);
  import dsir_pkg::*;

  logic    main_q;
  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t result;
  logic    advance;
  logic    s_fire;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      main_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire)       in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance)            out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.kind        <= kind_e'(s_axis_tuser);
      in_q.reg_offset  <= s_axis_tdata[15:0];
      in_q.access_size <= s_axis_tdata[17:16];
      in_q.write_data  <= s_axis_tdata[49:18];
      in_q.line_number <= s_axis_tdata[58:50];
    end
    if (advance) out_q <= result;
  end

  dsir_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .is_main_cpu_i (main_q),
    .result_o      (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.pending_flags, out_q.framebuffer_dma,
                          out_q.hblank_dma, out_q.vblank_dma, out_q.read_data};

  a_rd_zero_non_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.kind != KIND_READ) |=> out_q.read_data == 32'd0)
    else $error("read data nonzero on a non-read beat");

  a_dma_main_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !main_q |=> !out_q.hblank_dma && !out_q.framebuffer_dma)
    else $error("hblank/framebuffer DMA trigger without main processor");

  a_dma_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.vblank_dma && out_q.hblank_dma))
    else $error("vblank and hblank DMA triggers in one beat");

endmodule

`default_nettype wire

FILE: rtl/dsir_regs.sv
// ----------------------------------------------------------------------------
// Display status / interrupt register file
// Holds status, enables and flags; decodes one beat and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module dsir_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire dsir_pkg::item_t  item_i,
  input  wire logic             is_main_cpu_i,
  output dsir_pkg::result_t     result_o
);
  import dsir_pkg::*;

  logic        in_vblank_q, in_vblank_d;
  logic        in_hblank_q, in_hblank_d;
  logic        in_match_q, in_match_d;
  logic [8:0]  line_cmp_q, line_cmp_d;
  logic        vblank_ie_q, vblank_ie_d;
  logic        hblank_ie_q, hblank_ie_d;
  logic        match_ie_q, match_ie_d;
  logic        gate_q, gate_d;
  logic [31:0] irq_en_q, irq_en_d;
  logic [31:0] irq_flag_q, irq_flag_d;

  logic [31:0] mask;
  logic [31:0] wdata;
  logic [15:0] reg_addr;
  logic [8:0]  line;

  assign reg_addr = {item_i.reg_offset[15:2], 2'b00};
  assign line     = item_i.line_number;

  always_comb begin
    unique case (item_i.access_size)
      SIZE_BYTE: mask = 32'h0000_00ff << {item_i.reg_offset[1:0], 3'b000};
      SIZE_HALF: mask = item_i.reg_offset[1] ? 32'hffff_0000 : 32'h0000_ffff;
      default:   mask = 32'hffff_ffff;
    endcase
  end

  assign wdata = item_i.write_data & mask;

  always_comb begin
    in_vblank_d = in_vblank_q;
    in_hblank_d = in_hblank_q;
    in_match_d  = in_match_q;
    line_cmp_d  = line_cmp_q;
    vblank_ie_d = vblank_ie_q;
    hblank_ie_d = hblank_ie_q;
    match_ie_d  = match_ie_q;
    gate_d      = gate_q;
    irq_en_d    = irq_en_q;
    irq_flag_d  = irq_flag_q;

    result_o.read_data       = '0;
    result_o.vblank_dma      = 1'b0;
    result_o.hblank_dma      = 1'b0;
    result_o.framebuffer_dma = 1'b0;

    unique case (item_i.kind)
      KIND_READ: begin
        unique case (reg_addr)
          REG_DISPSTAT: begin
            result_o.read_data = {7'b0, line, line_cmp_q[7:0], line_cmp_q[8], 1'b0,
                                  match_ie_q, hblank_ie_q, vblank_ie_q,
                                  in_match_q, in_hblank_q, in_vblank_q};
          end
          REG_GATE: begin
            result_o.read_data = {31'b0, gate_q};
          end
          REG_IRQ_EN: begin
            result_o.read_data = irq_en_q;
          end
          REG_IRQ_FLAG: begin
            result_o.read_data = irq_flag_q;
          end
          default: ;
        endcase
      end
      KIND_WRITE: begin
        unique case (reg_addr)
          REG_DISPSTAT: begin
            if (|mask[15:8]) line_cmp_d[7:0] = wdata[15:8];
            if (mask[7])     line_cmp_d[8]   = wdata[7];
            if (|mask[5:0]) begin
              match_ie_d  = wdata[5];
              hblank_ie_d = wdata[4];
              vblank_ie_d = wdata[3];
            end
          end
          REG_GATE: begin
            if (mask[0]) gate_d = wdata[0];
          end
          REG_IRQ_EN: begin
            irq_en_d = (irq_en_q & ~mask) | wdata;
          end
          REG_IRQ_FLAG: begin
            // write one to clear
            irq_flag_d = irq_flag_q & ~wdata;
          end
          default: ;
        endcase
      end
      KIND_LINE: begin
        in_hblank_d = 1'b0;
        in_match_d  = 1'b0;
        if (line == VBLANK_LINE) begin
          in_vblank_d = 1'b1;
          if (vblank_ie_q) irq_flag_d[0] = 1'b1;
          result_o.vblank_dma = 1'b1;
        end
        if (line == LAST_LINE) in_vblank_d = 1'b0;
        result_o.framebuffer_dma = is_main_cpu_i && (line >= FB_FIRST) && (line < FB_END);
        if (line_cmp_q == line) begin
          in_match_d = 1'b1;
          if (match_ie_q) irq_flag_d[2] = 1'b1;
        end
      end
      KIND_HBLANK: begin
        in_hblank_d = 1'b1;
        if (hblank_ie_q) irq_flag_d[1] = 1'b1;
        result_o.hblank_dma = is_main_cpu_i && (line < VBLANK_LINE);
      end
      default: ;
    endcase

    result_o.pending_flags = irq_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vblank_q <= 1'b0;
      in_hblank_q <= 1'b0;
      in_match_q  <= 1'b0;
      line_cmp_q  <= '0;
      vblank_ie_q <= 1'b0;
      hblank_ie_q <= 1'b0;
      match_ie_q  <= 1'b0;
      gate_q      <= 1'b0;
      irq_en_q    <= '0;
      irq_flag_q  <= '0;
    end else if (step_i) begin
      in_vblank_q <= in_vblank_d;
      in_hblank_q <= in_hblank_d;
      in_match_q  <= in_match_d;
      line_cmp_q  <= line_cmp_d;
      vblank_ie_q <= vblank_ie_d;
      hblank_ie_q <= hblank_ie_d;
      match_ie_q  <= match_ie_d;
      gate_q      <= gate_d;
      irq_en_q    <= irq_en_d;
      irq_flag_q  <= irq_flag_d;
    end
  end

endmodule

`default_nettype wire
